/* rtl/grfc_pkg.sv */
// Package with shared constants and types for the gradient rectangle fill and compare block.
package grfc_pkg;

  // Frame store geometry.
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = $clog2(DEPTH);
  localparam int PIX_W      = 24;

  // Error sum limits.
  localparam int SUM_W = 30;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam int ADD_W = 18;

  // Request types.
  localparam logic REQ_DRAW    = 1'b0;
  localparam logic REQ_COMPARE = 1'b1;

  // Fill types.
  localparam logic [1:0] FILL_CONST = 2'd0;
  localparam logic [1:0] FILL_HORIZ = 2'd1;

  // Error modes.
  localparam logic MODE_ABS = 1'b0;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MODE   = 2'd2;

  // One gradient lane: quotient and remainder of the running numerator.
  typedef struct packed {
    logic [7:0] q;
    logic [6:0] r;
  } lane_t;

endpackage

/* rtl/grfc_ram.sv */
// Generic single-port synchronous RAM with a registered read.
module grfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // The write lands on the clock edge; the read data is registered and shows the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/gradient_rect_fill_compare_top.sv */
// Top level of the gradient rectangle fill and compare block.
//
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_stall   | request, position, size, colors, fill type
//  out_    | output    | out_valid/out_stall | stored pixel color, error sum
//  cfg_    | input     | cfg_valid/cfg_ready | register index, write data
//
// A non-empty draw runs its setup (the accept step and an 8-step divider for the gradient
// step, then one fix-up step), then writes one clipped pixel per cycle through the single frame
// store port, then posts the result; an empty draw posts its result straight after the accept.
// A compare runs accept, store read, difference (absolute or squared), saturating sum, result.
// Reset is synchronous, active low; the frame store is not cleared.
// A stalled result is held in the output register; one transaction is in flight at a time.
module gradient_rect_fill_compare_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [6:0]  in_pos_x,
  input  logic [6:0]  in_pos_y,
  input  logic [6:0]  in_rect_width,
  input  logic [6:0]  in_rect_height,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [1:0]  in_fill_type,
  input  logic [7:0]  in_red_end,
  input  logic [7:0]  in_green_end,
  input  logic [7:0]  in_blue_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_stored_red,
  output logic [7:0]  out_stored_green,
  output logic [7:0]  out_stored_blue,
  output logic [29:0] out_error_sum,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_FIX  = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_SUM  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  localparam int AW = grfc_pkg::AW;

  // Advance a lane by one step of the gradient numerator.
  function automatic grfc_pkg::lane_t adv(grfc_pkg::lane_t cur, logic [9:0] dq,
                                          logic [6:0] dr, logic [6:0] len);
    logic [7:0] r1;
    logic [9:0] qn;
    grfc_pkg::lane_t res;
    r1 = {1'b0, cur.r} + {1'b0, dr};
    qn = {2'b00, cur.q} + dq;
    if (r1 >= {1'b0, len}) begin
      r1 = r1 - {1'b0, len};
      qn = qn + 10'd1;
    end
    res.q = qn[7:0];
    res.r = r1[6:0];
    return res;
  endfunction

  logic [2:0]  state_r, state_nxt;
  logic [6:0]  fw_r, fh_r;
  logic        mode_r;
  logic        req_r;
  logic        hor_r;
  logic [6:0]  len_r;
  logic [6:0]  x0_r;
  logic [6:0]  cx_r, cy_r;
  logic [7:0]  xe_r, ye_r;
  logic [2:0]  cnt_r;
  logic [7:0]  dvd_r [3];
  logic [6:0]  rem_r [3];
  logic        neg_r [3];
  logic [9:0]  dq_r [3];
  logic [6:0]  dr_r [3];
  grfc_pkg::lane_t row_r [3];
  grfc_pkg::lane_t pix_r [3];
  grfc_pkg::lane_t row_adv [3];
  grfc_pkg::lane_t pix_adv [3];
  logic [7:0]  src_r [3];
  logic        inframe_r;
  logic [AW-1:0] cmp_addr_r;
  logic [grfc_pkg::ADD_W-1:0] add_r;
  logic [23:0] res_col_r;
  logic [grfc_pkg::SUM_W-1:0] sum_r;
  logic        out_valid_r;
  logic [23:0] out_col_r;
  logic [grfc_pkg::SUM_W-1:0] out_sum_r;

  logic        in_acc;
  logic [7:0]  fw_eff, fh_eff;
  logic [7:0]  xe_raw, ye_raw, xe_c, ye_c;
  logic        empty;
  logic [7:0]  start_c [3];
  logic [7:0]  end_c [3];

  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [23:0] ram_wdata, ram_rdata;
  logic [AW-1:0] fill_addr;
  logic [8:0]  diff [3];
  logic [7:0]  adiff [3];
  logic [15:0] sq [3];
  logic [grfc_pkg::ADD_W-1:0] add_c;
  logic [grfc_pkg::SUM_W:0] sum_ext;
  logic        out_free;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // Clipping against the effective frame size.
  always_comb begin
    fw_eff = ({1'b0, fw_r} > 8'(grfc_pkg::MAX_WIDTH)) ? 8'(grfc_pkg::MAX_WIDTH) : {1'b0, fw_r};
    fh_eff = ({1'b0, fh_r} > 8'(grfc_pkg::MAX_HEIGHT)) ? 8'(grfc_pkg::MAX_HEIGHT) : {1'b0, fh_r};
    xe_raw = {1'b0, in_pos_x} + {1'b0, in_rect_width};
    ye_raw = {1'b0, in_pos_y} + {1'b0, in_rect_height};
    xe_c   = (xe_raw > fw_eff) ? fw_eff : xe_raw;
    ye_c   = (ye_raw > fh_eff) ? fh_eff : ye_raw;
    empty  = (in_rect_width == 7'd0) || (in_rect_height == 7'd0) ||
             ({1'b0, in_pos_x} >= xe_c) || ({1'b0, in_pos_y} >= ye_c);
    start_c[0] = in_red;
    start_c[1] = in_green;
    start_c[2] = in_blue;
    end_c[0]   = in_red_end;
    end_c[1]   = in_green_end;
    end_c[2]   = in_blue_end;
  end

  // Lane stepping: the pixel lane moves along a row, the row lane down the rectangle.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pix_adv[i] = adv(pix_r[i], hor_r ? dq_r[i] : 10'd0, hor_r ? dr_r[i] : 7'd0, len_r);
      row_adv[i] = adv(row_r[i], hor_r ? 10'd0 : dq_r[i], hor_r ? 7'd0 : dr_r[i], len_r);
    end
  end

  // Frame store port: writes while filling, reads for a compare.
  always_comb begin
    fill_addr = AW'(cy_r) * AW'(grfc_pkg::MAX_WIDTH) + AW'(cx_r);
    ram_we    = (state_r == S_FILL);
    ram_addr  = (state_r == S_FILL) ? fill_addr : cmp_addr_r;
    ram_wdata = {pix_r[2].q, pix_r[1].q, pix_r[0].q};
  end

  grfc_ram #(
    .WIDTH(grfc_pkg::PIX_W),
    .DEPTH(grfc_pkg::DEPTH)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Channel differences and their error contribution.
  always_comb begin
    add_c = '0;
    for (int i = 0; i < 3; i++) begin
      diff[i]  = {1'b0, ram_rdata[8*i +: 8]} - {1'b0, src_r[i]};
      adiff[i] = diff[i][8] ? 8'(-diff[i]) : diff[i][7:0];
      sq[i]    = adiff[i] * adiff[i];
      if (mode_r == grfc_pkg::MODE_ABS) begin
        add_c = add_c + grfc_pkg::ADD_W'(adiff[i]);
      end else begin
        add_c = add_c + grfc_pkg::ADD_W'(sq[i]);
      end
    end
    sum_ext = {1'b0, sum_r} + (grfc_pkg::SUM_W + 1)'(add_r);
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_req_type == grfc_pkg::REQ_COMPARE) begin
            state_nxt = S_RD;
          end else if (empty) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV:  state_nxt = (cnt_r == 3'd7) ? S_FIX : S_DIV;
      S_FIX:  state_nxt = S_FILL;
      S_FILL: begin
        if ({1'b0, cx_r} + 8'd1 >= xe_r && {1'b0, cy_r} + 8'd1 >= ye_r) begin
          state_nxt = S_DONE;
        end
      end
      S_RD:   state_nxt = S_ACC;
      S_ACC:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_DONE;
      S_DONE: state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fw_r        <= 7'd64;
      fh_r        <= 7'd64;
      mode_r      <= grfc_pkg::MODE_ABS;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          grfc_pkg::CFG_WIDTH:  fw_r   <= cfg_data;
          grfc_pkg::CFG_HEIGHT: fh_r   <= cfg_data;
          grfc_pkg::CFG_MODE:   mode_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_acc && in_req_type == grfc_pkg::REQ_DRAW) begin
        sum_r <= '0;
      end else if (state_r == S_SUM) begin
        sum_r <= (sum_ext > (grfc_pkg::SUM_W + 1)'(grfc_pkg::SUM_MAX)) ?
                 grfc_pkg::SUM_MAX : sum_ext[grfc_pkg::SUM_W-1:0];
      end
      cnt_r <= (state_r == S_DIV) ? cnt_r + 3'd1 : 3'd0;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    logic [8:0] d;
    logic [7:0] rs;
    if (in_acc) begin
      req_r      <= in_req_type;
      hor_r      <= (in_fill_type == grfc_pkg::FILL_HORIZ);
      len_r      <= (in_fill_type == grfc_pkg::FILL_HORIZ) ? in_rect_width : in_rect_height;
      x0_r       <= in_pos_x;
      cx_r       <= in_pos_x;
      cy_r       <= in_pos_y;
      xe_r       <= xe_c;
      ye_r       <= ye_c;
      inframe_r  <= ({1'b0, in_pos_x} < fw_eff) && ({1'b0, in_pos_y} < fh_eff);
      cmp_addr_r <= AW'(in_pos_y) * AW'(grfc_pkg::MAX_WIDTH) + AW'(in_pos_x);
      for (int i = 0; i < 3; i++) begin
        d = (in_fill_type == grfc_pkg::FILL_CONST) ? 9'd0 :
            {1'b0, end_c[i]} - {1'b0, start_c[i]};
        neg_r[i]   <= d[8];
        dvd_r[i]   <= d[8] ? 8'(-d) : d[7:0];
        rem_r[i]   <= '0;
        row_r[i].q <= start_c[i];
        row_r[i].r <= '0;
        pix_r[i].q <= start_c[i];
        pix_r[i].r <= '0;
        src_r[i]   <= start_c[i];
      end
    end else if (state_r == S_DIV) begin
      // One restoring division step per lane.
      for (int i = 0; i < 3; i++) begin
        rs = {rem_r[i], dvd_r[i][7]};
        if (rs >= {1'b0, len_r}) begin
          rem_r[i] <= 7'(rs - {1'b0, len_r});
          dvd_r[i] <= {dvd_r[i][6:0], 1'b1};
        end else begin
          rem_r[i] <= rs[6:0];
          dvd_r[i] <= {dvd_r[i][6:0], 1'b0};
        end
      end
    end else if (state_r == S_FIX) begin
      // Turn the magnitude quotient into a floor step with a nonnegative remainder.
      for (int i = 0; i < 3; i++) begin
        if (!neg_r[i]) begin
          dq_r[i] <= {2'b00, dvd_r[i]};
          dr_r[i] <= rem_r[i];
        end else if (rem_r[i] == 7'd0) begin
          dq_r[i] <= 10'(-{2'b00, dvd_r[i]});
          dr_r[i] <= '0;
        end else begin
          dq_r[i] <= 10'(-{2'b00, dvd_r[i]}) - 10'd1;
          dr_r[i] <= len_r - rem_r[i];
        end
      end
    end else if (state_r == S_FILL) begin
      if ({1'b0, cx_r} + 8'd1 < xe_r) begin
        cx_r  <= cx_r + 7'd1;
        pix_r <= pix_adv;
      end else begin
        cx_r  <= x0_r;
        cy_r  <= cy_r + 7'd1;
        row_r <= row_adv;
        pix_r <= row_adv;
      end
    end else if (state_r == S_ACC) begin
      add_r     <= inframe_r ? add_c : '0;
      res_col_r <= inframe_r ? ram_rdata : 24'd0;
    end
    if (state_r == S_DONE && out_free) begin
      out_col_r <= (req_r == grfc_pkg::REQ_COMPARE) ? res_col_r : 24'd0;
      out_sum_r <= (req_r == grfc_pkg::REQ_COMPARE) ? sum_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_stored_red   = out_col_r[7:0];
  assign out_stored_green = out_col_r[15:8];
  assign out_stored_blue  = out_col_r[23:16];
  assign out_error_sum    = out_sum_r;

`ifndef NO_ASSERTIONS
  // The fill cursor stays inside the clipped rectangle.
  a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> ({1'b0, cx_r} < xe_r && {1'b0, cy_r} < ye_r))
    else $error("fill cursor outside rectangle");

  // Gradient remainders stay below the gradient length.
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> (pix_r[0].r < len_r && pix_r[1].r < len_r && pix_r[2].r < len_r))
    else $error("gradient remainder out of range");

  // An accepted transaction leaves the idle state.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted transaction not started");

  // A result appears only after the final sequencer state.
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result without completion");
`endif

endmodule
